/* design/block_quant_dequantizer_macros.svh */
// assertion macros for the block dequantizer
`ifndef BLOCK_QUANT_DEQUANTIZER_MACROS_SVH
`define BLOCK_QUANT_DEQUANTIZER_MACROS_SVH

// implication checked every clock, off during reset
`define BQD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define BQD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* design/bqd_pkg.sv */
// package: types, constants and fp helpers of the block dequantizer
package bqd_pkg;

  localparam logic [5:0] Q4_BLOCK_BYTES = 6'd18;
  localparam logic [5:0] Q8_BLOCK_BYTES = 6'd34;

  typedef enum logic [0:0] {
    FMT_Q4 = 1'b0,
    FMT_Q8 = 1'b1
  } fmt_t;

  // one weight job handed from the decoder to the multiplier
  typedef struct packed {
    logic [31:0] scale;
    logic [7:0]  q;
    logic [4:0]  index;
    logic        done;
    logic        lst;
  } job_t;

  // fp16 to fp32, inf and nan become +0
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [3:0]  lz;
    logic [9:0]  fn;
    logic [7:0]  ee;
    logic [31:0] r;
    s  = h[15];
    e  = h[14:10];
    f  = h[9:0];
    lz = 4'd0;
    fn = '0;
    ee = '0;
    r  = '0;
    if (e == 5'd0) begin
      if (f == 10'd0) begin
        r = {s, 31'd0};
      end else begin
        for (int i = 0; i < 10; i++) begin
          if (f[i]) lz = 4'(9 - i);
        end
        fn = 10'(f << (lz + 4'd1));
        ee = 8'(8'd112 - {4'd0, lz});
        r  = {s, ee, fn, 13'd0};
      end
    end else if (e == 5'd31) begin
      r = '0;
    end else begin
      r = {s, 8'({3'd0, e} + 8'd112), f, 13'd0};
    end
    return r;
  endfunction

endpackage

/* design/bqd_decode.sv */
// byte decoder: block position, scale capture, weight job generation
module bqd_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fmt,
  input  logic           take,
  input  logic [7:0]     data,
  output logic           emit,
  output logic           two,
  output bqd_pkg::job_t  job0,
  output bqd_pkg::job_t  job1
);
  import bqd_pkg::*;

  logic [5:0]  pos_r, pos_nxt, len, p;
  logic [15:0] scale_r, scale_nxt;
  logic [31:0] sc;
  logic        end_blk;
  logic [4:0]  j;

  always_comb begin
    len = (fmt == FMT_Q8) ? Q8_BLOCK_BYTES : Q4_BLOCK_BYTES;
    p   = (pos_r >= len) ? 6'd0 : pos_r;
    end_blk = (p + 6'd1 == len);
    j   = 5'(p - 6'd2);
    scale_nxt = scale_r;
    if (p == 6'd0) scale_nxt = {8'd0, data};
    else if (p == 6'd1) scale_nxt = {data, scale_r[7:0]};
    pos_nxt = end_blk ? 6'd0 : p + 6'd1;
    emit = take && (p > 6'd1);
    two  = (fmt == FMT_Q4);
    sc   = widen_half(scale_r);
    job0 = '0;
    job1 = '0;
    job0.scale = sc;
    job1.scale = sc;
    if (fmt == FMT_Q4) begin
      job0.q = 8'({4'd0, data[3:0]} - 8'd8);
      job0.index = 5'({j, 1'b0});
      job1.q = 8'({4'd0, data[7:4]} - 8'd8);
      job1.index = 5'({j, 1'b1});
      job1.done = end_blk;
      job1.lst  = 1'b1;
    end else begin
      job0.q = data;
      job0.index = j;
      job0.done = end_blk;
      job0.lst  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      scale_r <= '0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      scale_r <= scale_nxt;
    end
  end

endmodule

/* design/bqd_fmul.sv */
// fp32 scale times small signed integer, exact then rounded to nearest even
module bqd_fmul (
  input  logic [31:0] scale,
  input  logic [7:0]  q,
  output logic [31:0] prod
);
  import bqd_pkg::*;

  logic        s, qs;
  logic [7:0]  e, mq;
  logic [23:0] m;
  logic [31:0] pm;
  logic [2:0]  sh;
  logic [9:0]  ex;
  logic [31:0] nm;
  logic [23:0] mant;
  logic        g, st, up;
  logic [24:0] mr;

  always_comb begin
    s  = scale[31];
    e  = scale[30:23];
    qs = q[7];
    mq = qs ? 8'(-q) : q;
    m  = (e == 8'd0) ? {1'b0, scale[22:0]} : {1'b1, scale[22:0]};
    pm = m * {24'd0, mq};
    sh = 3'd0;
    for (int i = 24; i < 32; i++) begin
      if (pm[i]) sh = 3'(i - 23);
    end
    // normalize only upward; scale from fp16 is normal or zero-ish
    nm   = pm >> sh;
    mant = nm[23:0];
    g    = (sh == 3'd0) ? 1'b0 : pm[sh - 3'd1];
    st   = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (i < 32'(sh) - 1 && pm[i]) st = 1'b1;
    end
    up  = g && (st || mant[0]);
    mr  = {1'b0, mant} + {24'd0, up};
    ex  = {2'd0, e} + {7'd0, sh};
    if (mr[24]) begin
      mr = mr >> 1;
      ex = ex + 10'd1;
    end
    if (pm == 32'd0 || e == 8'd0) prod = {s ^ qs, 31'd0};
    else prod = {s ^ qs, ex[7:0], mr[22:0]};
  end

endmodule

/* design/block_quant_dequantizer.sv */
// block dequantizer top level
//  channel | signals                                         | dir
//  in      | in_valid in_ready in_data_byte                  | in
//  out     | out_valid out_ready out_weight_bits/_index/...  | out
//  cfg     | cfg_we cfg_quant_format                         | in
// one byte per cycle for q8 blocks when out is not stalled; a q4 data byte
// holds input until its first weight leaves the two-entry result buffer
// (one per cycle unless stalled); a byte's first weight shows next cycle
// synchronous active-low reset clears position, scale and format
// out stalls back-pressure the input through the result buffer
module block_quant_dequantizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_quant_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_weight_bits,
  output logic [4:0]  out_weight_index,
  output logic        out_block_done,
  output logic        out_last
);
  import bqd_pkg::*;
  `include "block_quant_dequantizer_macros.svh"

  logic          fmt_r;
  logic          take, emit, two;
  job_t          job0, job1;
  job_t          b0_r, b1_r;
  logic          v0_r, v1_r;
  logic          pop;
  logic [31:0]   p0, p1;
  logic [31:0]   w0_r, w1_r;

  assign pop      = v0_r && out_ready;
  assign in_ready = !v1_r && (!v0_r || pop);
  assign take     = in_valid && in_ready;

  bqd_decode u_dec (
    .clk (clk), .rst_n (rst_n), .fmt (fmt_r), .take (take), .data (in_data_byte),
    .emit (emit), .two (two), .job0 (job0), .job1 (job1)
  );

  bqd_fmul u_m0 (.scale (job0.scale), .q (job0.q), .prod (p0));
  bqd_fmul u_m1 (.scale (job1.scale), .q (job1.q), .prod (p1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_Q4;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_quant_format;
      if (take && emit) begin
        v0_r <= 1'b1;
        v1_r <= two;
      end else if (pop) begin
        v0_r <= v1_r;
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      b0_r <= job0;
      b1_r <= job1;
      w0_r <= p0;
      w1_r <= p1;
    end else if (pop) begin
      b0_r <= b1_r;
      w0_r <= w1_r;
    end
  end

  assign out_valid        = v0_r;
  assign out_weight_bits  = w0_r;
  assign out_weight_index = b0_r.index;
  assign out_block_done   = b0_r.done;
  assign out_last         = b0_r.lst;

  `BQD_ASSERT_IMP(a_v1_needs_v0, v1_r, v0_r)
  `BQD_ASSERT_IMP(a_no_take_full, v1_r, !in_ready)
  `BQD_ASSERT_IMP(a_pair_order, v1_r, !b0_r.lst)
  `BQD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid)

endmodule

/* bench/tb.sv */
// testbench for the block dequantizer: directed and random block streams with a local predictor
module tb;
  import bqd_pkg::*;

  typedef struct {
    logic [31:0] bits;
    logic [4:0]  index;
    logic        done;
    logic        lst;
  } weight_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_quant_format = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_weight_bits;
  logic [4:0]  out_weight_index;
  logic        out_block_done;
  logic        out_last;

  weight_t     pending_weights[$];
  fmt_t        model_fmt = FMT_Q4;
  logic [5:0]  model_pos = '0;
  logic [15:0] model_scale = '0;
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  int          mismatches = 0;

  block_quant_dequantizer DUT (.*);

  always #5 clk = ~clk;

  // fp16 scale times small integer, exact in fp32
  function automatic logic [31:0] scaled_weight(logic [15:0] h, int q);
    logic        sgn;
    int          m, x, mag, p, k, ex;
    logic [22:0] mant;
    sgn = h[15] ^ (q < 0);
    mag = (q < 0) ? -q : q;
    if (h[14:10] == 5'd31) begin
      m = 0;
      sgn = (q < 0);
      x = 0;
    end else if (h[14:10] == 5'd0) begin
      m = h[9:0];
      x = -24;
    end else begin
      m = {1'b1, h[9:0]};
      x = int'(h[14:10]) - 25;
    end
    p = m * mag;
    if (p == 0) return {sgn, 31'd0};
    k = 0;
    for (int i = 0; i < 20; i++) if (p[i]) k = i;
    ex = x + k + 127;
    mant = 23'(p << (23 - k));
    return {sgn, ex[7:0], mant};
  endfunction

  // append one expected weight
  function automatic void queue_weight(weight_t w);
    pending_weights.insert(pending_weights.size(), w);
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [5:0] len;
    logic [5:0] pos;
    logic       fin;
    len = (model_fmt == FMT_Q8) ? Q8_BLOCK_BYTES : Q4_BLOCK_BYTES;
    pos = model_pos;
    if (pos >= len) pos = '0;
    fin = (pos + 6'd1 == len);
    if (pos == 6'd0) begin
      model_scale = {8'd0, b};
    end else if (pos == 6'd1) begin
      model_scale = {b, model_scale[7:0]};
    end else if (model_fmt == FMT_Q4) begin
      queue_weight('{scaled_weight(model_scale, int'(b[3:0]) - 8),
                     5'((pos - 6'd2) * 2), 1'b0, 1'b0});
      queue_weight('{scaled_weight(model_scale, int'(b[7:4]) - 8),
                     5'((pos - 6'd2) * 2 + 1), fin, 1'b1});
    end else begin
      queue_weight('{scaled_weight(model_scale, int'($signed(b))),
                     5'(pos - 6'd2), fin, 1'b1});
    end
    pos = pos + 6'd1;
    if (pos >= len) pos = '0;
    model_pos = pos;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    weight_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_weights.size() == 0) begin
        report("unexpected transaction", out_weight_bits, 0);
      end else begin
        w = pending_weights.pop_front();
        if (out_weight_bits !== w.bits) report("weight_bits", out_weight_bits, w.bits);
        if (out_weight_index !== w.index) report("weight_index", out_weight_index, w.index);
        if (out_block_done !== w.done) report("block_done", out_block_done, w.done);
        if (out_last !== w.lst) report("last", out_last, w.lst);
      end
    end
  end

  // receiver with random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_format(fmt_t f);
    drain();
    cfg_we = 1'b1;
    cfg_quant_format = f;
    @(negedge clk);
    cfg_we = 1'b0;
    model_fmt = f;
  endtask

  task automatic send_block(logic [15:0] scale, int n_data);
    send_byte(scale[7:0]);
    send_byte(scale[15:8]);
    for (int i = 0; i < n_data; i++) send_byte(8'($urandom));
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(5))
      0: return {1'($urandom), 5'd0, 10'($urandom)};
      1: return {1'($urandom), 5'd31, 10'($urandom)};
      2: return {1'($urandom), 15'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_q4_extremes();
    set_format(FMT_Q4);
    send_byte(8'h00);
    send_byte(8'h3c);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h88);
    send_byte(8'h0f);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom));
  endtask

  task automatic test_q8_special_scales();
    set_format(FMT_Q8);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h00);
    send_byte(8'hff);
    for (int i = 0; i < 28; i++) send_byte(8'($urandom));
    send_block(16'h7c00, 0);
    send_byte(8'h05);
    send_byte(8'h80);
  endtask

  task automatic test_format_switch_midblock();
    set_format(FMT_Q8);
    send_block(16'h3555, 20);
    set_format(FMT_Q4);
    send_byte(8'h12);
    set_format(FMT_Q8);
    send_block(16'h8000, 32);
    send_block(16'h7e01, 1);
    set_format(FMT_Q4);
    send_byte(8'h34);
    send_byte(8'h56);
  endtask

  task automatic test_backpressure();
    set_format(FMT_Q4);
    calm = 1'b1;
    hold_cycles = 80;
    send_block(16'h4248, 16);
    calm = 1'b0;
    drain();
    set_format(FMT_Q8);
    hold_cycles = 80;
    send_block(pick_scale(), 32);
  endtask

  task automatic test_random_blocks();
    for (int blk = 0; blk < 23; blk++) begin
      if ($urandom_range(3) == 0) set_format(fmt_t'($urandom_range(1)));
      calm = (blk >= 10 && blk < 14);
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom));
      end else begin
        send_block(pick_scale(), (model_fmt == FMT_Q8) ? 32 : 16);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_q4_extremes();
    test_q8_special_scales();
    test_format_switch_midblock();
    test_backpressure();
    test_random_blocks();
    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb failed");
    $finish;
  end
endmodule
